### hdl/sdec_pkg.sv
// Shared constants and helpers for the signed decimal text formatter.
package sdec_pkg;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;

   // binary bits consumed per conversion cycle
   localparam int STEP_BITS = 4;

   // decimal digits needed for an unsigned magnitude of the given width
   function automatic int dec_digits(input int width);
      return (width * 30103) / 100000 + 1;
   endfunction

endpackage

### hdl/signed_int_to_decimal_ascii.sv
// Top level of the signed binary to ASCII decimal formatter.
// Each accepted word is a signed DATA_WIDTH-bit integer; its decimal text leaves as one
// character word per cycle while rsp_stall is low, most significant first, led by '-' when
// negative and with rsp_last_char set on the final digit. Zero gives a single '0'. A word
// leaves the queue, passes through the shift-add-3 converter (four bits per cycle), has its
// leading digit found, and is then emitted one character at a time, 1 to 11 characters at
// 32 bits. A two-word queue lets the input side keep taking words while the converter and
// the output register are busy.
module signed_int_to_decimal_ascii #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [DATA_WIDTH-1:0] req_value,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [7:0]                   rsp_character,
   output logic                         rsp_last_char
);

   logic                push_valid, push_stall;
   logic [DATA_WIDTH:0] push_data;
   logic                pop_valid, pop_stall;
   logic [DATA_WIDTH:0] pop_data;

   sdec_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_value  (req_value),
      .push_valid (push_valid),
      .push_stall (push_stall),
      .push_data  (push_data)
   );

   sdec_queue #(.WIDTH(DATA_WIDTH + 1)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_stall (push_stall),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_stall  (pop_stall),
      .pop_data   (pop_data)
   );

   sdec_back #(.DATA_WIDTH(DATA_WIDTH)) u_back (
      .clock         (clock),
      .reset         (reset),
      .pop_valid     (pop_valid),
      .pop_stall     (pop_stall),
      .pop_data      (pop_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_character (rsp_character),
      .rsp_last_char (rsp_last_char)
   );

   a_char_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_character == sdec_pkg::CHAR_MINUS) ||
                    (rsp_character >= sdec_pkg::CHAR_ZERO &&
                     rsp_character <= sdec_pkg::CHAR_NINE))
      else $error("illegal character on output");

   a_minus_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_character == sdec_pkg::CHAR_MINUS |-> !rsp_last_char)
      else $error("minus sign flagged as last character");

   a_idle_pops: assert property (@(posedge clock) disable iff (reset)
      pop_valid && !pop_stall |=> pop_stall)
      else $error("back end did not start on popped word");

endmodule

### hdl/sdec_front.sv
// Front end: takes a word, splits it into sign and unsigned magnitude.
module sdec_front #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [DATA_WIDTH-1:0] req_value,
   output logic                         push_valid,
   input  logic                         push_stall,
   output logic [DATA_WIDTH:0]          push_data
);

   logic                  negative;
   logic [DATA_WIDTH-1:0] magnitude;

   assign negative  = req_value[DATA_WIDTH-1];
   // most negative value maps onto 2^(W-1) as an unsigned magnitude
   assign magnitude = negative ? (~req_value + DATA_WIDTH'(1)) : req_value;

   assign push_valid = req_valid;
   assign req_stall  = push_stall;
   assign push_data  = {negative, magnitude};

endmodule

### hdl/sdec_queue.sv
// Two-entry queue between the front end and the conversion back end.
module sdec_queue #(
   parameter int WIDTH = 33
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_stall,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_stall,
   output logic [WIDTH-1:0] pop_data
);

   logic [WIDTH-1:0] entry_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             push, pop;

   assign push_stall = (count_ff == 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && !push_stall;
   assign pop        = pop_valid && !pop_stall;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### hdl/sdec_back.sv
// Back end: shift-add-3 binary to BCD conversion and character output.
module sdec_back #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                pop_valid,
   output logic                pop_stall,
   input  logic [DATA_WIDTH:0] pop_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [7:0]          rsp_character,
   output logic                rsp_last_char
);

   localparam int SB         = sdec_pkg::STEP_BITS;
   localparam int PAD_W      = ((DATA_WIDTH + SB - 1) / SB) * SB;
   localparam int STEPS      = PAD_W / SB;
   localparam int STEP_W     = (STEPS > 1) ? $clog2(STEPS) : 1;
   localparam int NUM_DIGITS = sdec_pkg::dec_digits(DATA_WIDTH);
   localparam int BCD_W      = NUM_DIGITS * 4;
   localparam int IDX_W      = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_CONV = 2'd1;
   localparam logic [1:0] S_FIND = 2'd2;
   localparam logic [1:0] S_EMIT = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [PAD_W-1:0] bin_ff, bin_in;
   logic [BCD_W-1:0] bcd_ff, bcd_in;
   logic             neg_ff, neg_in;
   logic             sign_pend_ff, sign_pend_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             out_valid_ff, out_valid_in;
   logic [7:0]       out_char_ff, out_char_in;
   logic             out_last_ff, out_last_in;

   logic [BCD_W-1:0] dab_bcd;
   logic [PAD_W-1:0] dab_bin;
   logic [IDX_W-1:0] top_idx;
   logic [3:0]       cur_digit;
   logic             slot_free;

   assign pop_stall     = (state_ff != S_IDLE);
   assign rsp_valid     = out_valid_ff;
   assign rsp_character = out_char_ff;
   assign rsp_last_char = out_last_ff;
   assign slot_free     = !out_valid_ff || !rsp_stall;
   assign cur_digit     = bcd_ff[idx_ff*4 +: 4];

   // STEP_BITS rounds of add-3 then shift
   always_comb begin
      logic [BCD_W-1:0] b;
      logic [PAD_W-1:0] m;
      b = bcd_ff;
      m = bin_ff;
      for (int k = 0; k < SB; k++) begin
         for (int d = 0; d < NUM_DIGITS; d++) begin
            if (b[d*4 +: 4] >= 4'd5) begin
               b[d*4 +: 4] = b[d*4 +: 4] + 4'd3;
            end
         end
         b = {b[BCD_W-2:0], m[PAD_W-1]};
         m = {m[PAD_W-2:0], 1'b0};
      end
      dab_bcd = b;
      dab_bin = m;
   end

   // highest non-zero digit, zero if the value is zero
   always_comb begin
      top_idx = '0;
      for (int d = 0; d < NUM_DIGITS; d++) begin
         if (bcd_ff[d*4 +: 4] != 4'd0) begin
            top_idx = IDX_W'(d);
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      bin_in       = bin_ff;
      bcd_in       = bcd_ff;
      neg_in       = neg_ff;
      sign_pend_in = sign_pend_ff;
      step_in      = step_ff;
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (pop_valid) begin
               bin_in   = PAD_W'(pop_data[DATA_WIDTH-1:0]);
               bcd_in   = '0;
               neg_in   = pop_data[DATA_WIDTH];
               step_in  = '0;
               state_in = S_CONV;
            end
         end
         S_CONV: begin
            bin_in  = dab_bin;
            bcd_in  = dab_bcd;
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(STEPS - 1)) begin
               state_in = S_FIND;
            end
         end
         S_FIND: begin
            idx_in       = top_idx;
            sign_pend_in = neg_ff;
            state_in     = S_EMIT;
         end
         S_EMIT: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               if (sign_pend_ff) begin
                  out_char_in  = sdec_pkg::CHAR_MINUS;
                  out_last_in  = 1'b0;
                  sign_pend_in = 1'b0;
               end else begin
                  out_char_in = sdec_pkg::CHAR_ZERO + {4'd0, cur_digit};
                  out_last_in = (idx_ff == '0);
                  if (idx_ff == '0) begin
                     state_in = S_IDLE;
                  end else begin
                     idx_in = idx_ff - IDX_W'(1);
                  end
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff       <= bin_in;
      bcd_ff       <= bcd_in;
      neg_ff       <= neg_in;
      sign_pend_ff <= sign_pend_in;
      step_ff      <= step_in;
      idx_ff       <= idx_in;
      out_char_ff  <= out_char_in;
      out_last_ff  <= out_last_in;
   end

endmodule
